### rtl/core/spf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Spectrum peak finder package
// Shared widths, register indexes, reset values, enum types and helpers.
// ---------------------------------------------------------------------------
package spf_pkg;

  // Configuration register widths and indexes.
  localparam int CNT_W      = 11;
  localparam int MARGIN_W   = 16;
  localparam int RATE_W     = 27;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 27;

  localparam logic [CFG_ADDR_W-1:0] CFG_BIN_COUNT   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PEAK_MARGIN = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_RATE = 2'd2;

  localparam logic [CNT_W-1:0]    RST_BIN_COUNT   = 11'd1024;
  localparam logic [MARGIN_W-1:0] RST_PEAK_MARGIN = 16'd3;
  localparam logic [RATE_W-1:0]   RST_SAMPLE_RATE = 27'd48000;

  // Result field widths.
  localparam int MAG_W     = 16;
  localparam int BIN_OUT_W = 10;
  localparam int SB_OUT_W  = 11;
  localparam int FREQ_W    = 28;
  localparam int SB_W      = CNT_W + 1;

  // Default parameter values.
  localparam int DEF_MAX_BINS    = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // Pending result slots, in delivery order.
  localparam int PEND_INT  = 0;
  localparam int PEND_ZERO = 1;
  localparam int PEND_LAST = 2;
  localparam int PEND_N    = 3;

  typedef enum logic [2:0] {
    ARITH_NOP,
    ARITH_MUL,
    ARITH_MAC,
    ARITH_SQRT,
    ARITH_DIV
  } arith_op_e;

  typedef struct packed {
    logic      valid;
    arith_op_e op;
  } arith_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_ROOT_GO,
    ST_ROOT,
    ST_JUDGE,
    ST_PICK,
    ST_FMUL,
    ST_DIV_GO,
    ST_DIV,
    ST_EMIT
  } spf_state_e;

  // Accumulator width: holds re^2 + im^2 and |signed bin| * sample rate.
  function automatic int acc_width(input int sample_bits);
    int w;
    w = 2 * sample_bits;
    if (w < CNT_W + RATE_W) begin
      w = CNT_W + RATE_W;
    end
    return w;
  endfunction

  // Largest usable bin count, bounded by what the count register can hold.
  function automatic int max_count(input int max_bins);
    int n;
    n = max_bins;
    if (n > (1 << CNT_W) - 1) begin
      n = (1 << CNT_W) - 1;
    end
    return n;
  endfunction

  function automatic logic is_peak(input logic [MAG_W-1:0]    prev,
                                   input logic [MAG_W-1:0]    cand,
                                   input logic [MAG_W-1:0]    next,
                                   input logic [MARGIN_W-1:0] margin);
    logic [MAG_W:0] lim_p;
    logic [MAG_W:0] lim_n;
    lim_p = {1'b0, prev} + {1'b0, margin};
    lim_n = {1'b0, next} + {1'b0, margin};
    return ({1'b0, cand} >= lim_p) && ({1'b0, cand} >= lim_n);
  endfunction

endpackage
`default_nettype wire

### rtl/core/spf_arith.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Spectrum peak finder shared arithmetic unit
// One multiplier with accumulate, and one compare-subtract step that serves
// both the bitwise square root and the restoring division.
// ---------------------------------------------------------------------------
module spf_arith #(
  parameter int SAMPLE_BITS = spf_pkg::DEF_SAMPLE_BITS
) (
  input  wire                                          clk_i,
  input  wire                                          rst_ni,
  input  spf_pkg::arith_cmd_t                          cmd_i,
  input  wire [(SAMPLE_BITS > spf_pkg::CNT_W ? SAMPLE_BITS : spf_pkg::CNT_W)-1:0]   mul_a_i,
  input  wire [(SAMPLE_BITS > spf_pkg::RATE_W ? SAMPLE_BITS : spf_pkg::RATE_W)-1:0] mul_b_i,
  input  wire [spf_pkg::CNT_W-1:0]                     divisor_i,
  output logic                                         busy_o,
  output logic [spf_pkg::acc_width(SAMPLE_BITS)-1:0]   result_o
);
  import spf_pkg::*;

  localparam int MA_W   = (SAMPLE_BITS > CNT_W) ? SAMPLE_BITS : CNT_W;
  localparam int MB_W   = (SAMPLE_BITS > RATE_W) ? SAMPLE_BITS : RATE_W;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = acc_width(SAMPLE_BITS);
  localparam int ROOT_W = ACC_W / 2;
  localparam int R_W    = (ROOT_W + 1 > CNT_W) ? ROOT_W + 1 : CNT_W;
  localparam int T_W    = R_W + 2;
  localparam int STEP_W = $clog2(ACC_W + 1);

  logic [ACC_W-1:0]  w_q, w_d;
  logic [ACC_W-1:0]  res_q, res_d;
  logic [R_W-1:0]    rem_q, rem_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              sqrt_q, sqrt_d;
  logic              busy_q, busy_d;

  logic [PROD_W-1:0] prod;
  logic [T_W-1:0]    shifted;
  logic [T_W-1:0]    trial;
  logic [T_W-1:0]    diff;
  logic              ge;

  assign prod = {{MB_W{1'b0}}, mul_a_i} * {{MA_W{1'b0}}, mul_b_i};

  // Square root brings in two radicand bits per step, division one.
  always_comb begin
    if (sqrt_q) begin
      shifted = {rem_q, w_q[ACC_W-1:ACC_W-2]};
      trial   = {res_q[R_W-1:0], 2'b01};
    end else begin
      shifted = {1'b0, rem_q, w_q[ACC_W-1]};
      trial   = {{(T_W-CNT_W){1'b0}}, divisor_i};
    end
    diff = shifted - trial;
    ge   = (shifted >= trial);
  end

  always_comb begin
    w_d    = w_q;
    res_d  = res_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    sqrt_d = sqrt_q;
    busy_d = busy_q;
    if (busy_q) begin
      rem_d = ge ? diff[R_W-1:0] : shifted[R_W-1:0];
      res_d = {res_q[ACC_W-2:0], ge};
      w_d   = sqrt_q ? {w_q[ACC_W-3:0], 2'b00} : {w_q[ACC_W-2:0], 1'b0};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
      end
    end else if (cmd_i.valid) begin
      case (cmd_i.op)
        ARITH_MUL: begin
          w_d = prod[ACC_W-1:0];
        end
        ARITH_MAC: begin
          w_d = w_q + prod[ACC_W-1:0];
        end
        ARITH_SQRT: begin
          rem_d  = '0;
          res_d  = '0;
          cnt_d  = STEP_W'(ROOT_W);
          sqrt_d = 1'b1;
          busy_d = 1'b1;
        end
        ARITH_DIV: begin
          rem_d  = '0;
          res_d  = '0;
          cnt_d  = STEP_W'(ACC_W);
          sqrt_d = 1'b0;
          busy_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      sqrt_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      sqrt_q <= sqrt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    res_q <= res_d;
    rem_q <= rem_d;
  end

  assign busy_o   = busy_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

### rtl/core/spectrum_peak_finder.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Spectrum peak finder
// Reports bins whose magnitude clears both circular neighbours by a margin.
// ---------------------------------------------------------------------------
// Bins of one frame arrive in order, bin 0 first, one per input transfer.
// Each bin's magnitude is the floor square root of re^2 + im^2, saturated to
// 16 bits. All arithmetic runs through one shared unit: a multiplier for the
// squares and the frequency product, and a compare-subtract stage that
// produces one root bit or one quotient bit per cycle. A bin is finished,
// including the frequency division for every peak it reports and any output
// stall, before the next one is accepted. Bins 0 and count-1 are reported on
// the last bin of the frame, after the interior result, and the final result
// of each input is marked with tlast.
module spectrum_peak_finder #(
  parameter int MAX_BINS    = spf_pkg::DEF_MAX_BINS,
  parameter int SAMPLE_BITS = spf_pkg::DEF_SAMPLE_BITS
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Input bins.
  input  wire                                s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // bin_real [SAMPLE_BITS-1:0], bin_imag [2*SAMPLE_BITS-1:SAMPLE_BITS]
  input  wire [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata_i,
  // Peak results.
  output logic                               m_axis_tvalid_o,
  input  wire                                m_axis_tready_i,
  // peak_bin [9:0], signed_bin [20:10], peak_frequency_hz [48:21]
  output logic [55:0]                        m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  // Configuration writes.
  input  wire                                cfg_we_i,
  input  wire [spf_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  wire [spf_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import spf_pkg::*;

  localparam int MA_W    = (SAMPLE_BITS > CNT_W) ? SAMPLE_BITS : CNT_W;
  localparam int MB_W    = (SAMPLE_BITS > RATE_W) ? SAMPLE_BITS : RATE_W;
  localparam int ACC_W   = acc_width(SAMPLE_BITS);
  localparam int MAX_N   = max_count(MAX_BINS);
  localparam int POS_W   = $clog2(MAX_N);
  localparam int OUT_W   = BIN_OUT_W + SB_OUT_W + FREQ_W;
  localparam int OUT_PAD = 56 - OUT_W;

  // Configuration registers.
  logic [CNT_W-1:0]    bin_count_q;
  logic [MARGIN_W-1:0] peak_margin_q;
  logic [RATE_W-1:0]   sample_rate_q;

  // Frame state.
  logic [MAG_W-1:0] first_mag_q, second_mag_q, older_mag_q, newer_mag_q;
  logic [POS_W-1:0] pos_q;

  // Per-bin working registers.
  logic [SAMPLE_BITS-1:0] abs_re_q, abs_im_q;
  logic [POS_W-1:0]       cur_q;
  logic                   last_q;
  logic [PEND_N-1:0]      pend_q;
  logic [PEND_N-1:0]      sel_q;
  logic [CNT_W-1:0]       res_bin_q;
  logic [SB_W-1:0]        res_sb_q;
  logic [CNT_W-1:0]       res_mag_q;
  logic                   res_neg_q;

  // Output register.
  logic                   out_valid_q;
  logic [OUT_W-1:0]       out_data_q;
  logic                   out_last_q;

  spf_state_e state_q, state_d;

  arith_cmd_t        cmd;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic              arith_busy;
  logic [ACC_W-1:0]  arith_res;

  logic [CNT_W-1:0]       eff_n;
  logic [CNT_W-1:0]       n_m1;
  logic                   in_xfer;
  logic                   out_free;
  logic [SAMPLE_BITS-1:0] raw_re, raw_im;
  logic [SAMPLE_BITS-1:0] abs_re, abs_im;
  logic                   frame_end;
  logic [POS_W-1:0]       pos_eff;
  logic [MAG_W-1:0]       mag;
  logic [MAG_W-1:0]       first_nxt, second_nxt;
  logic [PEND_N-1:0]      pend_nxt;
  logic [PEND_N-1:0]      pick;
  logic [CNT_W-1:0]       pick_bin;
  logic                   pick_neg;
  logic [CNT_W-1:0]       pick_mag;
  logic [FREQ_W-1:0]      quot;
  logic [FREQ_W-1:0]      freq;
  logic [PEND_N-1:0]      pend_left;

  // Count clamped to the supported range.
  always_comb begin
    if (bin_count_q < CNT_W'(2)) begin
      eff_n = CNT_W'(2);
    end else if (bin_count_q > CNT_W'(MAX_N)) begin
      eff_n = CNT_W'(MAX_N);
    end else begin
      eff_n = bin_count_q;
    end
    n_m1 = eff_n - CNT_W'(1);
  end

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign raw_re = s_axis_tdata_i[SAMPLE_BITS-1:0];
  assign raw_im = s_axis_tdata_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign abs_re = raw_re[SAMPLE_BITS-1] ? (~raw_re + SAMPLE_BITS'(1)) : raw_re;
  assign abs_im = raw_im[SAMPLE_BITS-1] ? (~raw_im + SAMPLE_BITS'(1)) : raw_im;

  // A position at or past the end closes the frame as bin count-1.
  assign frame_end = CNT_W'(pos_q) >= n_m1;
  assign pos_eff   = frame_end ? n_m1[POS_W-1:0] : pos_q;

  // Magnitude saturates to 16 bits.
  assign mag = (|arith_res[ACC_W-1:MAG_W]) ? {MAG_W{1'b1}} : arith_res[MAG_W-1:0];

  always_comb begin
    first_nxt  = (cur_q == '0) ? mag : first_mag_q;
    second_nxt = (cur_q == POS_W'(1)) ? mag : second_mag_q;
    pend_nxt   = '0;
    pend_nxt[PEND_INT]  = (CNT_W'(cur_q) >= CNT_W'(2)) &&
                          is_peak(older_mag_q, newer_mag_q, mag, peak_margin_q);
    pend_nxt[PEND_ZERO] = last_q && is_peak(mag, first_nxt, second_nxt, peak_margin_q);
    pend_nxt[PEND_LAST] = last_q && is_peak(newer_mag_q, mag, first_nxt, peak_margin_q);
  end

  // Earliest pending result and its signed bin.
  always_comb begin
    pick     = '0;
    pick_bin = '0;
    if (pend_q[PEND_INT]) begin
      pick[PEND_INT] = 1'b1;
      pick_bin       = CNT_W'(cur_q) - CNT_W'(1);
    end else if (pend_q[PEND_ZERO]) begin
      pick[PEND_ZERO] = 1'b1;
      pick_bin        = '0;
    end else if (pend_q[PEND_LAST]) begin
      pick[PEND_LAST] = 1'b1;
      pick_bin        = n_m1;
    end
    pick_neg = pick_bin > (eff_n >> 1);
    pick_mag = pick_neg ? (eff_n - pick_bin) : pick_bin;
  end

  assign quot      = arith_res[FREQ_W-1:0];
  assign freq      = res_neg_q ? (~quot + FREQ_W'(1)) : quot;
  assign pend_left = pend_q & ~sel_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = ST_SQ_RE;
        end
      end
      ST_SQ_RE:   state_d = ST_SQ_IM;
      ST_SQ_IM:   state_d = ST_ROOT_GO;
      ST_ROOT_GO: state_d = ST_ROOT;
      ST_ROOT: begin
        if (!arith_busy) begin
          state_d = ST_JUDGE;
        end
      end
      ST_JUDGE:   state_d = ST_PICK;
      ST_PICK: begin
        state_d = (pend_q == '0) ? ST_IDLE : ST_FMUL;
      end
      ST_FMUL:    state_d = ST_DIV_GO;
      ST_DIV_GO:  state_d = ST_DIV;
      ST_DIV: begin
        if (!arith_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_PICK;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: input ready, shared unit command and operand selection.
  always_comb begin
    cmd.valid       = 1'b0;
    cmd.op          = ARITH_NOP;
    mul_a           = '0;
    mul_b           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
      end
      ST_SQ_RE: begin
        cmd.valid = 1'b1;
        cmd.op    = ARITH_MUL;
        mul_a     = MA_W'(abs_re_q);
        mul_b     = MB_W'(abs_re_q);
      end
      ST_SQ_IM: begin
        cmd.valid = 1'b1;
        cmd.op    = ARITH_MAC;
        mul_a     = MA_W'(abs_im_q);
        mul_b     = MB_W'(abs_im_q);
      end
      ST_ROOT_GO: begin
        cmd.valid = 1'b1;
        cmd.op    = ARITH_SQRT;
      end
      ST_FMUL: begin
        cmd.valid = 1'b1;
        cmd.op    = ARITH_MUL;
        mul_a     = MA_W'(res_mag_q);
        mul_b     = MB_W'(sample_rate_q);
      end
      ST_DIV_GO: begin
        cmd.valid = 1'b1;
        cmd.op    = ARITH_DIV;
      end
      default: begin
      end
    endcase
  end

  spf_arith #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_arith (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .mul_a_i   (mul_a),
    .mul_b_i   (mul_b),
    .divisor_i (eff_n),
    .busy_o    (arith_busy),
    .result_o  (arith_res)
  );

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      bin_count_q   <= RST_BIN_COUNT;
      peak_margin_q <= RST_PEAK_MARGIN;
      sample_rate_q <= RST_SAMPLE_RATE;
      first_mag_q   <= '0;
      second_mag_q  <= '0;
      older_mag_q   <= '0;
      newer_mag_q   <= '0;
      pos_q         <= '0;
      pend_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_BIN_COUNT:   bin_count_q   <= cfg_wdata_i[CNT_W-1:0];
          CFG_PEAK_MARGIN: peak_margin_q <= cfg_wdata_i[MARGIN_W-1:0];
          CFG_SAMPLE_RATE: sample_rate_q <= cfg_wdata_i[RATE_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_xfer) begin
        pos_q <= frame_end ? '0 : pos_q + POS_W'(1);
      end
      if (state_q == ST_JUDGE) begin
        first_mag_q  <= first_nxt;
        second_mag_q <= second_nxt;
        older_mag_q  <= newer_mag_q;
        newer_mag_q  <= mag;
        pend_q       <= pend_nxt;
      end
      if (state_q == ST_EMIT && out_free) begin
        pend_q      <= pend_left;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      abs_re_q <= abs_re;
      abs_im_q <= abs_im;
      cur_q    <= pos_eff;
      last_q   <= frame_end;
    end
    if (state_q == ST_PICK) begin
      sel_q     <= pick;
      res_bin_q <= pick_bin;
      res_neg_q <= pick_neg;
      res_mag_q <= pick_mag;
      res_sb_q  <= pick_neg ? (~{1'b0, pick_mag} + SB_W'(1)) : {1'b0, pick_bin};
    end
    if (state_q == ST_EMIT && out_free) begin
      out_data_q <= {freq, res_sb_q[SB_OUT_W-1:0], res_bin_q[BIN_OUT_W-1:0]};
      out_last_q <= (pend_left == '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD{1'b0}}, out_data_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule
`default_nettype wire

### tb/tb_spectrum_peak_finder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Spectrum peak finder testbench
// Streams complex bins through the peak finder under random input bursts and
// output stalls. Every accepted bin is run through a local predictor. Each
// result transfer is checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_spectrum_peak_finder;
  import spf_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_BINS   = 420;
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int COUNT_CAP     = DEF_MAX_BINS;
  localparam int REPORT_CAP    = 60;

  // The imaginary part sits above the real part, as on the input bus.
  typedef struct packed {
    logic signed [15:0] im;
    logic signed [15:0] re;
  } bin_t;

  typedef struct {
    logic [BIN_OUT_W-1:0] bin;
    logic [SB_OUT_W-1:0]  sbin;
    logic [FREQ_W-1:0]    freq;
    logic                 last;
  } peak_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  s_tvalid  = 1'b0;
  wire                   s_tready;
  logic [31:0]           s_tdata   = '0;
  wire                   m_tvalid;
  logic                  m_tready  = 1'b0;
  wire  [55:0]           m_tdata;
  wire                   m_tlast;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Register copies and frame state of the predictor.
  logic [CNT_W-1:0]    count_reg  = RST_BIN_COUNT;
  logic [MARGIN_W-1:0] margin_reg = RST_PEAK_MARGIN;
  logic [RATE_W-1:0]   rate_reg   = RST_SAMPLE_RATE;
  int unsigned mag_first  = 0;
  int unsigned mag_second = 0;
  int unsigned mag_older  = 0;
  int unsigned mag_newer  = 0;
  int unsigned frame_pos  = 0;

  bin_t  bin_q[$];
  peak_t peak_q[$];
  bin_t  cur_bin;
  peak_t seen;
  bit    bin_taken     = 1'b0;
  int    burst_left    = 0;
  int    gap_left      = 0;
  int    ready_hold    = 0;
  bit    ready_next    = 1'b0;
  int    bins_queued   = 0;
  int    bins_accepted = 0;
  int    mismatches    = 0;
  int    cycles        = 0;

  spectrum_peak_finder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic int unsigned floor_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > x) probe >>= 2;
    while (probe != 0) begin
      if (x >= root + probe) begin
        x    = x - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return int'(root);
  endfunction

  function automatic int unsigned magnitude_of(bin_t b);
    longint      re;
    longint      im;
    int unsigned root;
    re   = b.re;
    im   = b.im;
    root = floor_sqrt(longint'(re * re + im * im));
    return (root > 65535) ? 65535 : root;
  endfunction

  function automatic int unsigned frame_len();
    int unsigned n;
    n = count_reg;
    if (n < 2) n = 2;
    if (n > COUNT_CAP) n = COUNT_CAP;
    return n;
  endfunction

  function automatic bit clears(int unsigned prev, int unsigned cand, int unsigned next);
    return cand >= prev + margin_reg && cand >= next + margin_reg;
  endfunction

  function automatic peak_t make_peak(int unsigned bin, int unsigned n);
    peak_t  p;
    longint sb;
    longint span;
    longint freq;
    sb     = (bin > n / 2) ? longint'(bin) - longint'(n) : longint'(bin);
    span   = (sb < 0 ? -sb : sb) * longint'(rate_reg) / longint'(n);
    freq   = (sb < 0) ? -span : span;
    p.bin  = bin[BIN_OUT_W-1:0];
    p.sbin = sb[SB_OUT_W-1:0];
    p.freq = freq[FREQ_W-1:0];
    p.last = 1'b0;
    return p;
  endfunction

  // Judges the bins that this one completes and queues their peak results.
  task automatic predict_peaks(bin_t b);
    int unsigned n;
    int unsigned m;
    int unsigned pos;
    bit          closing;
    peak_t       found[$];
    n       = frame_len();
    m       = magnitude_of(b);
    pos     = frame_pos;
    closing = pos >= n - 1;
    // A count shrunk below the current position closes the frame here.
    if (closing) pos = n - 1;
    if (pos == 0) mag_first = m;
    if (pos == 1) mag_second = m;
    if (pos >= 2 && clears(mag_older, mag_newer, m)) found.push_back(make_peak(pos - 1, n));
    if (closing) begin
      if (clears(m, mag_first, mag_second)) found.push_back(make_peak(0, n));
      if (clears(mag_newer, m, mag_first)) found.push_back(make_peak(n - 1, n));
    end
    mag_older = mag_newer;
    mag_newer = m;
    frame_pos = closing ? 0 : pos + 1;
    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    foreach (found[i]) peak_q.push_back(found[i]);
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatches < REPORT_CAP)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Input side: bins are taken from the queue in bursts with idle gaps between.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_tvalid || bin_taken)) begin
      bin_taken = 1'b0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
      end
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (bin_q.size() > 0) begin
        cur_bin = bin_q.pop_front();
        s_tdata  <= cur_bin;
        s_tvalid <= 1'b1;
        burst_left--;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready) begin
      predict_peaks(cur_bin);
      bins_accepted++;
      bin_taken = 1'b1;
    end
  end

  // Output side: ready and stall stretches of random length, chosen at random.
  always @(negedge clk_i) begin
    if (ready_hold == 0) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          ready_next = 1'b1;
          ready_hold = $urandom_range(1, 8);
        end
        2: begin
          ready_next = 1'b1;
          ready_hold = $urandom_range(50, 200);
        end
        3: begin
          ready_next = 1'b0;
          ready_hold = $urandom_range(10, 45);
        end
        default: begin
          ready_next = 1'b0;
          ready_hold = $urandom_range(1, 3);
        end
      endcase
    end else begin
      ready_hold--;
    end
    m_tready <= ready_next;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (peak_q.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 0);
      end else begin
        seen = peak_q.pop_front();
        if (m_tdata[9:0] !== seen.bin) report_mismatch("peak_bin", m_tdata[9:0], seen.bin);
        if (m_tdata[20:10] !== seen.sbin)
          report_mismatch("signed_bin", m_tdata[20:10], seen.sbin);
        if (m_tdata[48:21] !== seen.freq)
          report_mismatch("peak_frequency_hz", m_tdata[48:21], seen.freq);
        if (m_tdata[55:49] !== '0) report_mismatch("tdata padding", m_tdata[55:49], 0);
        if (m_tlast !== seen.last) report_mismatch("last_of_run", m_tlast, seen.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_spectrum_peak_finder: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_BIN_COUNT:   count_reg  = value[CNT_W-1:0];
      CFG_PEAK_MARGIN: margin_reg = value[MARGIN_W-1:0];
      CFG_SAMPLE_RATE: rate_reg   = value[RATE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_bin(int re, int im);
    bin_t b;
    b.re = 16'(re);
    b.im = 16'(im);
    bin_q.push_back(b);
    bins_queued++;
  endtask

  // Waits until every bin is taken and every result delivered, then lets a bin
  // that reports nothing finish before the next register write.
  task automatic drain();
    while (bins_accepted != bins_queued || peak_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Mostly small values so that margins decide, with full-scale and spikes mixed in.
  function automatic logic [15:0] draw_part();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0, 1: v = 16'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      3: begin
        v = 16'($urandom_range(2000, 32767));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = 16'($urandom_range(0, 24) - 12);
    endcase
    return v;
  endfunction

  initial begin
    int sent;
    int run;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Four-bin frames: full-scale parts, an interior peak and a peak on the last bin.
    write_reg(CFG_BIN_COUNT, 4);
    write_reg(CFG_PEAK_MARGIN, 3);
    write_reg(CFG_SAMPLE_RATE, 48000);
    queue_bin(0, 0);
    queue_bin(32767, -32768);
    queue_bin(0, 0);
    queue_bin(100, 0);
    queue_bin(-32768, 0);
    queue_bin(5, 5);
    queue_bin(3, -4);
    queue_bin(0, 0);
    drain();

    // Zero margin on a flat frame: every bin is a peak, three results on the last.
    write_reg(CFG_PEAK_MARGIN, 0);
    write_reg(CFG_SAMPLE_RATE, 27'h7FFFFFF);
    repeat (4) queue_bin(-32768, -32768);
    drain();

    // Two-bin frame with a zero sample rate.
    write_reg(CFG_BIN_COUNT, 2);
    write_reg(CFG_PEAK_MARGIN, 3);
    write_reg(CFG_SAMPLE_RATE, 0);
    queue_bin(7, 0);
    queue_bin(1, 0);
    drain();

    // A count below two acts as two.
    write_reg(CFG_BIN_COUNT, 0);
    write_reg(CFG_SAMPLE_RATE, 100000000);
    queue_bin(0, 9);
    queue_bin(0, -1);
    queue_bin(0, 1);
    queue_bin(0, -20);
    drain();

    // A count above the maximum acts as the maximum; the frame is then cut short
    // by shrinking the count below the current position.
    write_reg(CFG_BIN_COUNT, 2047);
    write_reg(CFG_PEAK_MARGIN, 2);
    queue_bin(1, 1);
    queue_bin(40, 0);
    queue_bin(2, 2);
    drain();
    write_reg(CFG_BIN_COUNT, 3);
    queue_bin(-1, -1);
    drain();

    sent = 0;
    while (sent < RANDOM_BINS) begin
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0: write_reg(CFG_BIN_COUNT, $urandom_range(0, 1));
          1: write_reg(CFG_BIN_COUNT, $urandom_range(13, 64));
          2: begin
            case ($urandom_range(0, 2))
              0: write_reg(CFG_BIN_COUNT, COUNT_CAP);
              1: write_reg(CFG_BIN_COUNT, 2047);
              default: write_reg(CFG_BIN_COUNT, $urandom_range(COUNT_CAP + 1, 2047));
            endcase
          end
          default: write_reg(CFG_BIN_COUNT, $urandom_range(2, 12));
        endcase
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          4: write_reg(CFG_PEAK_MARGIN, 65535);
          5: write_reg(CFG_PEAK_MARGIN, 16'($urandom));
          default: write_reg(CFG_PEAK_MARGIN, $urandom_range(0, 8));
        endcase
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0: write_reg(CFG_SAMPLE_RATE, 0);
          1: write_reg(CFG_SAMPLE_RATE, 1);
          2: write_reg(CFG_SAMPLE_RATE, 27'h7FFFFFF);
          3: write_reg(CFG_SAMPLE_RATE, 100000000);
          4: write_reg(CFG_SAMPLE_RATE, 48000);
          default: write_reg(CFG_SAMPLE_RATE, $urandom_range(1, 100000000));
        endcase
      end
      run = $urandom_range(4, 40);
      repeat (run) queue_bin(int'($signed(draw_part())), int'($signed(draw_part())));
      sent += run;
      drain();
    end

    if (mismatches == 0) begin
      $display("tb_spectrum_peak_finder: PASS");
    end else begin
      $display("tb_spectrum_peak_finder: FAIL");
    end
    $finish;
  end

endmodule
